/* rtl/core/chatan_pkg.sv */
// Shared widths, angle table and pipeline payload type for the compass heading block.
`default_nettype none

package chatan_pkg;

    // Fixed field widths.
    localparam int FIELD_W   = 16;
    localparam int HEADING_W = 15;

    // Vector components hold the readings scaled by 2^16, plus headroom for
    // the negation of the most negative reading and the CORDIC gain.
    localparam int VEC_SCALE = 16;
    localparam int VEC_W     = 35;

    // The angle accumulator counts 2^-20 degree.
    localparam int ACC_FRAC  = 20;
    localparam int ACC_W     = 31;
    localparam int TABLE_LEN = 24;

    // Defaults for the top level parameters.
    localparam int ITERATIONS_DEF          = 16;
    localparam int ANGLE_FRACTION_BITS_DEF = 6;

    localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(180 << ACC_FRAC);
    localparam logic signed [ACC_W-1:0] FULL_TURN = ACC_W'(360 << ACC_FRAC);

    // atan(2^-i) in degrees, in units of 2^-20 degree, rounded to nearest.
    localparam logic signed [ACC_W-1:0] ARC_TABLE [TABLE_LEN] = '{
        31'sd47185920, 31'sd27855475, 31'sd14718068, 31'sd7471121,
        31'sd3750058,  31'sd1876857,  31'sd938658,   31'sd469357,
        31'sd234682,   31'sd117342,   31'sd58671,    31'sd29335,
        31'sd14668,    31'sd7334,     31'sd3667,     31'sd1833,
        31'sd917,      31'sd458,      31'sd229,      31'sd115,
        31'sd57,       31'sd29,       31'sd14,       31'sd7
    };

    // Payload carried between pipeline stages.
    typedef struct packed {
        logic                    zero;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ACC_W-1:0] acc;
    } vec_t;

endpackage

`default_nettype wire

/* rtl/core/chatan_prep.sv */
// Entry stage: scales the readings, folds the left half plane and seeds the angle.
`default_nettype none

module chatan_prep (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                field_valid,
    output logic                                     field_ready,
    input  wire logic signed [chatan_pkg::FIELD_W-1:0] field_x,
    input  wire logic signed [chatan_pkg::FIELD_W-1:0] field_y,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output chatan_pkg::vec_t                         out_data
);
    import chatan_pkg::*;

    localparam int EXT_W = VEC_W - FIELD_W - VEC_SCALE;

    logic                    valid_reg;
    vec_t                    data_reg;
    vec_t                    data_next;
    logic signed [VEC_W-1:0] x_scaled;
    logic signed [VEC_W-1:0] y_scaled;
    logic                    left_half;

    assign field_ready = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_data    = data_reg;

    always_comb
    begin
        x_scaled  = {{EXT_W{field_x[FIELD_W-1]}}, field_x, {VEC_SCALE{1'b0}}};
        y_scaled  = {{EXT_W{field_y[FIELD_W-1]}}, field_y, {VEC_SCALE{1'b0}}};
        left_half = field_x[FIELD_W-1];

        data_next.zero = (field_x == '0) && (field_y == '0);
        if (left_half)
        begin
            data_next.x   = -x_scaled;
            data_next.y   = -y_scaled;
            data_next.acc = HALF_TURN;
        end
        else
        begin
            data_next.x   = x_scaled;
            data_next.y   = y_scaled;
            data_next.acc = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (field_ready)
        begin
            valid_reg <= field_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (field_ready && field_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/chatan_rot_stage.sv */
// One CORDIC vectoring micro-rotation with its own pipeline register.
`default_nettype none

module chatan_rot_stage #(
    parameter int STAGE = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire chatan_pkg::vec_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output chatan_pkg::vec_t       out_data
);
    import chatan_pkg::*;

    logic                    valid_reg;
    vec_t                    data_reg;
    vec_t                    data_next;
    logic signed [VEC_W-1:0] x_shift;
    logic signed [VEC_W-1:0] y_shift;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        x_shift        = in_data.x >>> STAGE;
        y_shift        = in_data.y >>> STAGE;
        data_next.zero = in_data.zero;
        // A non-negative y turns the vector clockwise and adds the table angle.
        if (!in_data.y[VEC_W-1])
        begin
            data_next.x   = in_data.x + y_shift;
            data_next.y   = in_data.y - x_shift;
            data_next.acc = in_data.acc + ARC_TABLE[STAGE];
        end
        else
        begin
            data_next.x   = in_data.x - y_shift;
            data_next.y   = in_data.y + x_shift;
            data_next.acc = in_data.acc - ARC_TABLE[STAGE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/chatan_round.sv */
// Two output stages: wrap and round the angle, then fold a full turn to zero.
`default_nettype none

module chatan_round #(
    parameter int ANGLE_FRACTION_BITS = chatan_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire chatan_pkg::vec_t                   in_data,
    output logic                                    heading_valid,
    input  wire logic                               heading_ready,
    output logic [chatan_pkg::HEADING_W-1:0]        heading
);
    import chatan_pkg::*;

    localparam int DROP = ACC_FRAC - ANGLE_FRACTION_BITS;
    localparam int RW   = ACC_W - 1 - DROP;

    localparam logic signed [ACC_W-1:0] RND_BIAS      = ACC_W'(1 << (DROP - 1));
    localparam logic signed [ACC_W-1:0] WRAP_RND_BIAS = FULL_TURN + RND_BIAS;
    localparam logic [RW-1:0]           TURN_STEPS    = RW'(360 << ANGLE_FRACTION_BITS);

    logic                    rnd_valid_reg;
    logic [RW-1:0]           rnd_reg;
    logic [RW-1:0]           rnd_next;
    logic signed [ACC_W-1:0] biased;
    logic                    rnd_ready;

    logic                    out_valid_reg;
    logic [HEADING_W-1:0]    heading_reg;
    logic [HEADING_W-1:0]    heading_next;

    assign rnd_ready     = !out_valid_reg || heading_ready;
    assign in_ready      = !rnd_valid_reg || rnd_ready;
    assign heading_valid = out_valid_reg;
    assign heading       = heading_reg;

    // A negative angle gets a full turn added in the same sum as the rounding bias.
    always_comb
    begin
        biased   = in_data.acc + (in_data.acc[ACC_W-1] ? WRAP_RND_BIAS : RND_BIAS);
        rnd_next = in_data.zero ? '0 : biased[ACC_W-2:DROP];
    end

    always_comb
    begin
        if (rnd_reg >= TURN_STEPS)
        begin
            heading_next = HEADING_W'(rnd_reg - TURN_STEPS);
        end
        else
        begin
            heading_next = HEADING_W'(rnd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                rnd_valid_reg <= in_valid;
            end
            if (rnd_ready)
            begin
                out_valid_reg <= rnd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rnd_reg <= rnd_next;
        end
        if (rnd_ready && rnd_valid_reg)
        begin
            heading_reg <= heading_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/compass_heading_atan2_top.sv */
// Top level of the pipelined CORDIC compass heading unit.
//
//   Channel   Direction  Handshake                    Payload
//   field     in         field_valid / field_ready    field_x, field_y (signed 16 bits)
//   heading   out        heading_valid / heading_ready heading (unsigned 15 bits)
//
// While the output is not stalled, an item enters every cycle: one item per clock,
// set by the unrolled chain of one register stage per micro-rotation.
// An item passes through one entry stage, one stage per micro-rotation, one
// rounding stage and the output register.
// Each stage holds its item while the next stage is full and stalled; a stage
// that is empty takes a new item even during a stall, so bubbles are squeezed out.
// Reset clears only the valid bits; the data registers carry no reset.
`default_nettype none

module compass_heading_atan2_top #(
    parameter int ITERATIONS          = chatan_pkg::ITERATIONS_DEF,
    parameter int ANGLE_FRACTION_BITS = chatan_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  field_valid,
    output logic                                       field_ready,
    input  wire logic signed [chatan_pkg::FIELD_W-1:0] field_x,
    input  wire logic signed [chatan_pkg::FIELD_W-1:0] field_y,
    output logic                                       heading_valid,
    input  wire logic                                  heading_ready,
    output logic [chatan_pkg::HEADING_W-1:0]           heading
);
    import chatan_pkg::*;

    // The angle table covers 24 micro-rotations; more iterations add nothing.
    localparam int NUM_ROT = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

    // Link k feeds micro-rotation k; link NUM_ROT feeds the rounding stages.
    logic stage_valid [NUM_ROT+1];
    logic stage_ready [NUM_ROT+1];
    vec_t stage_data  [NUM_ROT+1];

    // Entry stage: scale, fold the left half plane onto the right and seed
    // the accumulator with 180 degrees when folded.
    chatan_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .field_valid (field_valid),
        .field_ready (field_ready),
        .field_x     (field_x),
        .field_y     (field_y),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_data    (stage_data[0])
    );

    // One registered micro-rotation per iteration. Each drives y toward zero
    // and accumulates the signed table angle.
    for (genvar k = 0; k < NUM_ROT; k++)
    begin : g_rot
        chatan_rot_stage #(
            .STAGE (k)
        ) u_rot (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    // Wrap a negative angle, round half up to the output step, and turn a
    // rounded full turn into zero. A zero input vector gives zero.
    chatan_round #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_round (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (stage_valid[NUM_ROT]),
        .in_ready      (stage_ready[NUM_ROT]),
        .in_data       (stage_data[NUM_ROT]),
        .heading_valid (heading_valid),
        .heading_ready (heading_ready),
        .heading       (heading)
    );

endmodule

`default_nettype wire

/* rtl/core/chatan_checker.sv */
// Port-level assertions for the compass heading unit and their bind to the top level.
`default_nettype none

module chatan_checker #(
    parameter int ITERATIONS          = chatan_pkg::ITERATIONS_DEF,
    parameter int ANGLE_FRACTION_BITS = chatan_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  field_valid,
    input  wire logic                                  field_ready,
    input  wire logic                                  heading_valid,
    input  wire logic                                  heading_ready,
    input  wire logic [chatan_pkg::HEADING_W-1:0]      heading
);
    import chatan_pkg::*;

    localparam int NUM_ROT = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
    localparam int DEPTH   = NUM_ROT + 3;
    localparam int CNT_W   = $clog2(DEPTH + 2);
    localparam int LIMIT   = 360 << ANGLE_FRACTION_BITS;

    logic             in_fire;
    logic             out_fire;
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    assign in_fire  = field_valid && field_ready;
    assign out_fire = heading_valid && heading_ready;

    always_comb
    begin
        inflight_next = inflight_reg + CNT_W'(in_fire) - CNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A result waiting on the output is held until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        heading_valid && !heading_ready |=> heading_valid && $stable(heading))
        else $error("heading changed or dropped while stalled");

    // No result appears without an item in flight.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        heading_valid |-> inflight_reg != '0)
        else $error("result without an accepted item");

    // The pipeline never holds more items than it has stages.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(DEPTH))
        else $error("more items in flight than pipeline stages");

    // With a free stage anywhere, the input side must take an item.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg < CNT_W'(DEPTH) |-> field_ready)
        else $error("input stalled while the pipeline has room");

    // With up to 6 angle fraction bits, the heading stays below a full turn.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        heading_valid |-> (ANGLE_FRACTION_BITS > 6) || (32'(heading) < LIMIT))
        else $error("heading at or beyond a full turn");

endmodule

bind compass_heading_atan2_top chatan_checker #(
    .ITERATIONS          (ITERATIONS),
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
) u_chatan_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .field_valid   (field_valid),
    .field_ready   (field_ready),
    .heading_valid (heading_valid),
    .heading_ready (heading_ready),
    .heading       (heading)
);

`default_nettype wire
